@@ sv/orbital_alpha_derivative_ratio_assert.svh @@
`ifndef ORBITAL_ALPHA_DERIVATIVE_RATIO_ASSERT_SVH
`define ORBITAL_ALPHA_DERIVATIVE_RATIO_ASSERT_SVH
// Clocked checks that are switched off while reset is high.
`define OADR_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked checks that also hold while reset is high.
`define OADR_RESET_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ sv/oadr_pkg.sv @@
package oadr_pkg;
  localparam int RADW = 24;
  localparam int NW = 192;
  localparam int LIMB = 32;
  localparam int LIMBS = NW / LIMB;
  localparam int STEPS = 8;
  localparam int QB = 41;
  localparam int RW = NW + QB + 2;
  localparam logic [39:0] POS_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] NEG_MAG = 40'h80_0000_0000;
  localparam logic [4:0] LAST_INDEX = 5'd17;

  typedef logic [NW-1:0] poly_t;

  typedef struct packed {
    logic valid;
    logic bad;
    logic [2:0] grp;
    logic [RADW-1:0] r;
    poly_t ns;
    poly_t nacc;
    poly_t ds;
    poly_t dacc;
  } poly_stage_t;

  typedef struct packed {
    logic valid;
    logic bad;
    logic zden;
    logic sn;
    logic nzero;
    logic neg;
    logic [RW-1:0] rem;
    logic [RW-1:0] den;
    logic [QB:0] q;
  } div_t;

  function automatic logic [2:0] grp_of(input logic [4:0] idx);
    logic [2:0] g;
    unique case (idx)
      5'd0: g = 3'd0;
      5'd1: g = 3'd1;
      5'd2, 5'd3, 5'd4: g = 3'd2;
      5'd5: g = 3'd3;
      5'd6, 5'd7, 5'd8: g = 3'd4;
      5'd9, 5'd10, 5'd11, 5'd12, 5'd13: g = 3'd5;
      5'd14: g = 3'd6;
      default: g = 3'd7;
    endcase
    return g;
  endfunction

  function automatic logic [2:0] shell_of(input logic [2:0] g);
    logic [2:0] m;
    unique case (g)
      3'd0: m = 3'd1;
      3'd1, 3'd2: m = 3'd2;
      3'd3, 3'd4, 3'd5: m = 3'd3;
      default: m = 3'd4;
    endcase
    return m;
  endfunction

  function automatic logic signed [11:0] coef(input logic [2:0] g, input logic den,
                                               input logic [1:0] i);
    logic signed [11:0] c;
    c = 12'sd0;
    unique case ({g, den})
      {3'd1, 1'b0}: case (i) 2'd0: c = -12'sd4; 2'd1: c = 12'sd1; default: c = 12'sd0; endcase
      {3'd1, 1'b1}: case (i) 2'd0: c = -12'sd2; 2'd1: c = 12'sd1; default: c = 12'sd0; endcase
      {3'd3, 1'b0}: case (i)
          2'd0: c = 12'sd81; 2'd1: c = -12'sd30; 2'd2: c = 12'sd2; default: c = 12'sd0;
        endcase
      {3'd3, 1'b1}: case (i)
          2'd0: c = 12'sd27; 2'd1: c = -12'sd18; 2'd2: c = 12'sd2; default: c = 12'sd0;
        endcase
      {3'd4, 1'b0}: case (i) 2'd0: c = -12'sd9; 2'd1: c = 12'sd1; default: c = 12'sd0; endcase
      {3'd4, 1'b1}: case (i) 2'd0: c = -12'sd6; 2'd1: c = 12'sd1; default: c = 12'sd0; endcase
      {3'd6, 1'b0}: case (i)
          2'd0: c = -12'sd768; 2'd1: c = 12'sd336; 2'd2: c = -12'sd36; default: c = 12'sd1;
        endcase
      {3'd6, 1'b1}: case (i)
          2'd0: c = -12'sd192; 2'd1: c = 12'sd144; 2'd2: c = -12'sd24; default: c = 12'sd1;
        endcase
      {3'd7, 1'b0}: case (i)
          2'd0: c = 12'sd160; 2'd1: c = -12'sd28; 2'd2: c = 12'sd1; default: c = 12'sd0;
        endcase
      {3'd7, 1'b1}: case (i)
          2'd0: c = 12'sd80; 2'd1: c = -12'sd20; 2'd2: c = 12'sd1; default: c = 12'sd0;
        endcase
      default: c = (i == 2'd0) ? 12'sd1 : 12'sd0;
    endcase
    return c;
  endfunction
endpackage

@@ sv/orbital_alpha_derivative_ratio.sv @@
// Evaluates -Z*r*p(x)/(m*q(x)) with x = k*r for hydrogenic orbitals 0 to 17, exactly
// on integers, truncated toward zero and saturated to a signed 40-bit word. One word
// is accepted per cycle, but the whole pipeline holds while the output is stalled. It
// has one stage to load the leading coefficients, 48 multiply-accumulate stages (eight
// products, one 32-bit limb per stage), one for sign and magnitude, 42 of restoring
// division (one quotient bit per stage), and the output register.
module orbital_alpha_derivative_ratio import oadr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic wr_index,
  input  logic [23:0] wr_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [23:0] radius,
  input  logic [4:0] orbital_index,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [39:0] log_derivative,
  output logic bad_index,
  output logic zero_denominator
);
  `include "orbital_alpha_derivative_ratio_assert.svh"

  localparam logic IDX_K = 1'b0;
  localparam logic IDX_Z = 1'b1;
  localparam int STG = STEPS * LIMBS;

  logic [23:0] k_scale;
  logic [5:0] nuclear_charge;
  logic adv;

  poly_stage_t ps [0:STG];
  div_t dv [0:QB+1];

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_scale <= 24'd65536;
      nuclear_charge <= 6'd2;
    end else if (wr_en) begin
      unique case (wr_index)
        IDX_K: k_scale <= wr_data;
        IDX_Z: nuclear_charge <= wr_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ps[0].valid <= 1'b0;
    end else if (adv) begin
      ps[0].valid <= in_valid;
      ps[0].bad <= orbital_index > LAST_INDEX;
      ps[0].grp <= grp_of(orbital_index);
      ps[0].r <= radius;
      ps[0].ns <= NW'(coef(grp_of(orbital_index), 1'b0, 2'd3));
      ps[0].nacc <= '0;
      ps[0].ds <= NW'(coef(grp_of(orbital_index), 1'b1, 2'd3));
      ps[0].dacc <= '0;
    end
  end

  // Horner steps alternate between k and r, adding the next coefficient after each r;
  // the last two steps scale the numerator by Z and r and the denominator by m.
  for (genvar s = 0; s < STG; s++) begin : g_mac
    localparam int M = s / LIMBS;
    localparam int L = s % LIMBS;
    localparam int SH = 2 * FRAC_BITS * (M / 2 + 1);
    localparam logic [1:0] CI = 2'(2 - M / 2);
    localparam bit ADD_C = (M % 2 == 1) && (M < STEPS - 2);
    localparam bit BY_K = (M % 2 == 0) && (M < STEPS - 2);
    poly_stage_t nxt;
    logic [RADW-1:0] nmul, dmul;
    logic [LIMB+RADW-1:0] np, dp;
    poly_t nbase, dbase;
    always_comb begin
      nmul = ps[s].r;
      dmul = ps[s].r;
      if (BY_K) begin
        nmul = k_scale;
        dmul = k_scale;
      end else if (M == STEPS - 2) begin
        nmul = RADW'(nuclear_charge);
        dmul = RADW'(shell_of(ps[s].grp));
      end else if (M == STEPS - 1) begin
        dmul = RADW'(1);
      end
      np = ps[s].ns[L*LIMB +: LIMB] * nmul;
      dp = ps[s].ds[L*LIMB +: LIMB] * dmul;
      if (L != 0) begin
        nbase = ps[s].nacc;
        dbase = ps[s].dacc;
      end else if (ADD_C) begin
        nbase = NW'(coef(ps[s].grp, 1'b0, CI)) << SH;
        dbase = NW'(coef(ps[s].grp, 1'b1, CI)) << SH;
      end else begin
        nbase = '0;
        dbase = '0;
      end
      nxt = ps[s];
      nxt.nacc = nbase + (NW'(np) << (L * LIMB));
      nxt.dacc = dbase + (NW'(dp) << (L * LIMB));
      if (L == LIMBS - 1) begin
        nxt.ns = nxt.nacc;
        nxt.ds = nxt.dacc;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        ps[s+1].valid <= 1'b0;
      end else if (adv) begin
        ps[s+1] <= nxt;
      end
    end
  end

  // The numerator is the negated product, so its sign is the opposite of the product's.
  div_t dv0;
  logic [NW-1:0] nabs, dabs;
  logic num_zero;
  always_comb begin
    num_zero = ps[STG].ns == '0;
    nabs = ps[STG].ns[NW-1] ? -ps[STG].ns : ps[STG].ns;
    dabs = ps[STG].ds[NW-1] ? -ps[STG].ds : ps[STG].ds;
    dv0.valid = ps[STG].valid;
    dv0.bad = ps[STG].bad;
    dv0.zden = ps[STG].ds == '0;
    dv0.sn = !ps[STG].ns[NW-1] && !num_zero;
    dv0.nzero = num_zero;
    dv0.neg = dv0.sn ^ ps[STG].ds[NW-1];
    dv0.rem = RW'(nabs);
    dv0.den = RW'(dabs);
    dv0.q = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (adv) begin
      dv[0] <= dv0;
    end
  end

  for (genvar b = 0; b <= QB; b++) begin : g_div
    oadr_div_stage #(.BIT(QB - b)) u_stage (
      .clk(clk), .rst(rst), .en(adv), .prev(dv[b]), .cur(dv[b+1])
    );
  end

  div_t fin;
  logic [39:0] mag, res;
  logic big;
  assign fin = dv[QB+1];

  always_comb begin
    big = fin.q[QB] || fin.q[QB-1];
    mag = fin.q[39:0];
    if (fin.bad) begin
      res = '0;
    end else if (fin.zden) begin
      res = fin.nzero ? '0 : (fin.sn ? NEG_MAG : POS_MAX);
    end else if (fin.neg) begin
      if (big || mag > NEG_MAG) mag = NEG_MAG;
      res = -mag;
    end else begin
      if (big || mag > POS_MAX) mag = POS_MAX;
      res = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      log_derivative <= res;
      bad_index <= fin.bad;
      zero_denominator <= !fin.bad && fin.zden;
    end
  end

  logic res_zero, res_end;
  assign res_zero = log_derivative == '0;
  assign res_end = res_zero || log_derivative == POS_MAX || log_derivative == NEG_MAG;

  `OADR_CHECK(a_bad_zero, out_valid && bad_index |-> res_zero && !zero_denominator, "bad word")
  `OADR_CHECK(a_zden_sat, out_valid && zero_denominator |-> res_end, "zero denominator")
  `OADR_CHECK(a_stall_full, !in_ready |-> out_valid, "input stalled with an empty output")
  `OADR_RESET_CHECK(a_reset_empty, rst |=> !out_valid, "output valid after reset")
endmodule

@@ sv/oadr_div_stage.sv @@
module oadr_div_stage import oadr_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  div_t prev,
  output div_t cur
);
  logic [RW-1:0] trial;
  logic ge;
  div_t nxt;

  always_comb begin
    trial = prev.den << BIT;
    ge = prev.rem >= trial;
    nxt = prev;
    if (ge) begin
      nxt.rem = prev.rem - trial;
      nxt.q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur <= nxt;
    end
  end
endmodule

@@ verif/orbital_alpha_derivative_ratio_test.sv @@
module orbital_alpha_derivative_ratio_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam int LIMIT = 600000;
  localparam int DRAIN = 60;
  localparam logic [39:0] POS_END = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] NEG_END = 40'h80_0000_0000;
  localparam logic REG_K = 1'b0;
  localparam logic REG_Z = 1'b1;

  typedef logic signed [255:0] big_t;

  typedef struct {
    logic signed [39:0] value;
    logic bad;
    logic zden;
  } deriv_t;

  class deriv_scoreboard;
    logic [23:0] k_code;
    logic [5:0] charge;
    deriv_t pending[$];
    int errors;
    int coef_num[8][4];
    int coef_den[8][4];
    int group_of[18];
    int shell[8];

    function new();
      k_code = 24'd65536;
      charge = 6'd2;
      errors = 0;
      coef_num = '{'{1,0,0,0}, '{-4,1,0,0}, '{1,0,0,0}, '{81,-30,2,0},
                   '{-9,1,0,0}, '{1,0,0,0}, '{-768,336,-36,1}, '{160,-28,1,0}};
      coef_den = '{'{1,0,0,0}, '{-2,1,0,0}, '{1,0,0,0}, '{27,-18,2,0},
                   '{-6,1,0,0}, '{1,0,0,0}, '{-192,144,-24,1}, '{80,-20,1,0}};
      group_of = '{0,1,2,2,2,3,4,4,4,5,5,5,5,5,6,7,7,7};
      shell = '{1,2,2,3,3,3,4,4};
    endfunction

    function big_t horner(int c[4], big_t x);
      big_t acc;
      big_t term;
      acc = big_t'(c[3]);
      for (int i = 2; i >= 0; i--) begin
        term = big_t'(c[i]) <<< (2 * FRAC_BITS * (3 - i));
        acc = acc * x + term;
      end
      return acc;
    endfunction

    function deriv_t predict(logic [23:0] r, logic [4:0] idx);
      deriv_t res;
      big_t x, p, q, num, den;
      logic [255:0] an, ad, quo;
      int g;
      res.value = '0;
      res.bad = 1'b0;
      res.zden = 1'b0;
      if (idx > 5'd17) begin
        res.bad = 1'b1;
        return res;
      end
      g = group_of[idx];
      x = big_t'({232'd0, k_code}) * big_t'({232'd0, r});
      p = horner(coef_num[g], x);
      q = horner(coef_den[g], x);
      num = -(p * big_t'({250'd0, charge}) * big_t'({232'd0, r}));
      if (q == 0) begin
        res.zden = 1'b1;
        if (num == 0) res.value = '0;
        else if (num < 0) res.value = NEG_END;
        else res.value = POS_END;
        return res;
      end
      den = q * big_t'(shell[g]);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      quo = an / ad;
      if ((num < 0) != (den < 0)) begin
        if (quo > {216'd0, NEG_END}) quo = {216'd0, NEG_END};
        res.value = -quo[39:0];
      end else begin
        if (quo > {216'd0, POS_END}) quo = {216'd0, POS_END};
        res.value = quo[39:0];
      end
      return res;
    endfunction

    function void note_word(logic [23:0] r, logic [4:0] idx);
      pending.push_back(predict(r, idx));
    endfunction

    function void check_word(logic signed [39:0] v, logic b, logic z);
      deriv_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word %0d %b %b", v, b, z);
        return;
      end
      e = pending.pop_front();
      if (v !== e.value || b !== e.bad || z !== e.zden) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected %0d %b %b, got %0d %b %b",
                   e.value, e.bad, e.zden, v, b, z);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic wr_en;
  logic wr_index;
  logic [23:0] wr_data;
  logic in_valid;
  logic in_ready;
  logic [23:0] radius;
  logic [4:0] orbital_index;
  logic out_valid;
  logic out_ready;
  logic signed [39:0] log_derivative;
  logic bad_index;
  logic zero_denominator;

  deriv_scoreboard board;
  int cycles;
  int hold;
  int pick;

  orbital_alpha_derivative_ratio uut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .radius(radius),
    .orbital_index(orbital_index), .out_valid(out_valid), .out_ready(out_ready),
    .log_derivative(log_derivative), .bad_index(bad_index),
    .zero_denominator(zero_denominator)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_word(radius, orbital_index);
    if (!rst && out_valid && out_ready)
      board.check_word(log_derivative, bad_index, zero_denominator);
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      hold <= 0;
    end else if (hold > 0) begin
      hold <= hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        out_ready <= 1'b1;
        hold <= $urandom_range(0, 20);
      end else if (pick < 95) begin
        out_ready <= 1'b0;
        hold <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        hold <= $urandom_range(10, 60);
      end
    end
  end

  task automatic send_word(logic [23:0] r, logic [4:0] idx);
    int gap;
    pick = $urandom_range(0, 99);
    gap = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    radius <= r;
    orbital_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic sel, logic [23:0] data);
    wr_en <= 1'b1;
    wr_index <= sel;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    if (sel == REG_K) board.k_code = data;
    else board.charge = data[5:0];
    @(posedge clk);
  endtask

  task automatic random_words(int count);
    logic [23:0] r;
    logic [4:0] idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) r = 24'($urandom());
      else if (pick < 70) r = 24'($urandom_range(0, 24'h0F_FFFF));
      else if (pick < 80) r = 24'($urandom_range(0, 1023));
      else if (pick < 90) r = 24'($urandom_range(1, 30) << 16);
      else r = pick[0] ? 24'hFF_FFFF : 24'd0;
      idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(18, 31))
                                        : 5'($urandom_range(0, 17));
      send_word(r, idx);
    end
  endtask

  initial begin
    board = new();
    cycles = 0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_K;
    wr_data = '0;
    in_valid = 1'b0;
    radius = '0;
    orbital_index = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 18; i++) send_word(24'h01_8000, 5'(i));
    send_word(24'd0, 5'd14);
    send_word(24'hFF_FFFF, 5'd15);
    send_word(24'h02_0000, 5'd1);
    send_word(24'h06_0000, 5'd7);
    send_word(24'h04_0000, 5'd1);
    send_word(24'h12_3456, 5'd18);
    send_word(24'hFF_FFFF, 5'd31);
    random_words(150);
    drain();

    write_reg(REG_K, 24'd0);
    write_reg(REG_Z, 24'd1);
    random_words(160);
    drain();

    write_reg(REG_K, 24'hFF_FFFF);
    write_reg(REG_Z, 24'd36);
    random_words(160);
    drain();

    write_reg(REG_K, 24'h00_8000);
    write_reg(REG_Z, 24'd3);
    send_word(24'h04_0000, 5'd1);
    send_word(24'h0C_0000, 5'd8);
    random_words(160);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_K, 24'($urandom()));
      write_reg(REG_Z, 24'($urandom_range(1, 36)));
      random_words(160);
      drain();
    end

    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
